>>> src/spr_pkg.sv
// Shared types and constants for the shelf rectangle packer.
`timescale 1ns / 1ps

package spr_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 14;

    localparam logic [CFG_ADDR_W-1:0] REG_PAGE_WIDTH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PAGE_MARGIN  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GLYPH_MARGIN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MULTICHANNEL = 3'd4;

    localparam logic [13:0] PAGE_WIDTH_RST   = 14'd1024;
    localparam logic [13:0] PAGE_HEIGHT_RST  = 14'd1024;
    localparam logic [7:0]  PAGE_MARGIN_RST  = 8'd1;
    localparam logic [7:0]  GLYPH_MARGIN_RST = 8'd0;

    localparam int GLYPH_W   = 12;
    localparam int SLOT_W    = 13;
    localparam int CHAN_W    = 2;
    localparam int PAGE_W    = 16;

    localparam logic [CHAN_W-1:0] LAST_CHANNEL = 2'd3;
    localparam logic [PAGE_W-1:0] PAGE_MAX     = 16'hFFFF;
    localparam logic [PAGE_W-1:0] FIRST_PAGE   = 16'd1;

    typedef struct packed {
        logic [13:0] page_width;
        logic [13:0] page_height;
        logic [7:0]  page_margin;
        logic [7:0]  glyph_margin;
        logic        multichannel;
    } t_cfg;

endpackage

>>> src/spr_cfg.sv
// Configuration register file of the shelf rectangle packer.
`timescale 1ns / 1ps

module spr_cfg
    import spr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.page_width   <= PAGE_WIDTH_RST;
            r_cfg.page_height  <= PAGE_HEIGHT_RST;
            r_cfg.page_margin  <= PAGE_MARGIN_RST;
            r_cfg.glyph_margin <= GLYPH_MARGIN_RST;
            r_cfg.multichannel <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_PAGE_WIDTH:   r_cfg.page_width   <= i_cfg_data;
                REG_PAGE_HEIGHT:  r_cfg.page_height  <= i_cfg_data;
                REG_PAGE_MARGIN:  r_cfg.page_margin  <= i_cfg_data[7:0];
                REG_GLYPH_MARGIN: r_cfg.glyph_margin <= i_cfg_data[7:0];
                REG_MULTICHANNEL: r_cfg.multichannel <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> src/spr_calc.sv
// Placement logic: one slot against the current shelf cursor, and the next cursor state.
`timescale 1ns / 1ps

module spr_calc
    import spr_pkg::*;
#(
    parameter int COORD_BITS = 14
) (
    input  t_cfg                  i_cfg,
    input  logic [GLYPH_W-1:0]    i_glyph_width,
    input  logic [GLYPH_W-1:0]    i_glyph_height,
    input  logic [COORD_BITS:0]   i_cursor_x,
    input  logic [COORD_BITS:0]   i_cursor_y,
    input  logic [SLOT_W-1:0]     i_row_height,
    input  logic [CHAN_W-1:0]     i_channel,
    input  logic [PAGE_W-1:0]     i_page,
    output logic [COORD_BITS:0]   o_cursor_x,
    output logic [COORD_BITS:0]   o_cursor_y,
    output logic [SLOT_W-1:0]     o_row_height,
    output logic [CHAN_W-1:0]     o_channel,
    output logic [PAGE_W-1:0]     o_page,
    output logic [COORD_BITS-1:0] o_pos_x,
    output logic [COORD_BITS-1:0] o_pos_y,
    output logic [SLOT_W-1:0]     o_slot_width,
    output logic [SLOT_W-1:0]     o_slot_height,
    output logic                  o_page_closed,
    output logic                  o_oversize
);

    localparam int CUR_W = COORD_BITS + 1;
    // wide enough for cursor + slot or row height + margin without wrap
    localparam int SUM_W = ((CUR_W > SLOT_W) ? CUR_W : SLOT_W) + 2;
    localparam logic [SUM_W-1:0] CUR_MAX = {{(SUM_W-CUR_W){1'b0}}, {CUR_W{1'b1}}};

    logic [SUM_W-1:0] sw, sh, pm, pw, ph;
    logic [SUM_W-1:0] cx, cy, rh;
    logic [SUM_W-1:0] cy_row, cy_row_sat;
    logic [SUM_W-1:0] cx1, cy1, rh1;
    logic [SUM_W-1:0] cx2, cy2, rh2;
    logic [SUM_W-1:0] cx_adv;
    logic             miss_x, miss_y, close;

    always_comb begin
        sw = SUM_W'(i_glyph_width)  + SUM_W'({i_cfg.glyph_margin, 1'b0});
        sh = SUM_W'(i_glyph_height) + SUM_W'({i_cfg.glyph_margin, 1'b0});
        pm = SUM_W'(i_cfg.page_margin);
        pw = SUM_W'(i_cfg.page_width);
        ph = SUM_W'(i_cfg.page_height);
        cx = SUM_W'(i_cursor_x);
        cy = SUM_W'(i_cursor_y);
        rh = SUM_W'(i_row_height);

        o_oversize = (sw + (pm << 1) > pw) || (sh + (pm << 1) > ph);

        // row wrap
        miss_x     = (cx + sw + pm) > pw;
        cy_row     = cy + rh + pm;
        cy_row_sat = (cy_row > CUR_MAX) ? CUR_MAX : cy_row;
        cx1        = miss_x ? pm : cx;
        cy1        = miss_x ? cy_row_sat : cy;
        rh1        = miss_x ? '0 : rh;

        // page or channel change
        miss_y = (cy1 + sh + pm) > ph;
        close  = miss_y && (!i_cfg.multichannel || i_channel == LAST_CHANNEL);
        cx2    = miss_y ? pm : cx1;
        cy2    = miss_y ? pm : cy1;
        rh2    = miss_y ? '0 : rh1;

        o_channel = i_channel;
        if (miss_y && i_cfg.multichannel) begin
            o_channel = (i_channel == LAST_CHANNEL) ? '0 : i_channel + 1'b1;
        end
        o_page = (close && i_page != PAGE_MAX) ? i_page + 1'b1 : i_page;
        o_page_closed = close;

        o_pos_x       = cx2[COORD_BITS-1:0];
        o_pos_y       = cy2[COORD_BITS-1:0];
        o_slot_width  = sw[SLOT_W-1:0];
        o_slot_height = sh[SLOT_W-1:0];

        cx_adv       = cx2 + sw + pm;
        o_cursor_x   = (cx_adv > CUR_MAX) ? CUR_MAX[CUR_W-1:0] : cx_adv[CUR_W-1:0];
        o_cursor_y   = cy2[CUR_W-1:0];
        o_row_height = (sh > rh2) ? sh[SLOT_W-1:0] : rh2[SLOT_W-1:0];
    end

endmodule

>>> src/shelf_rectangle_packer_top.sv
// An accepted input beat passes through the input register, then the result register, to its result beat.
// One glyph per cycle while the result side is not stalled; cursor update is combinational.
// Input side stalls only when both the input and result registers are full and held.
// Reset (sync, active low): cursors to 1, row height 0, channel 0, page 1, config to defaults.
// Every input beat yields exactly one result beat; skipped items give all-zero results.
`timescale 1ns / 1ps

module shelf_rectangle_packer_top
    import spr_pkg::*;
#(
    parameter int COORD_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [23:0]           i_s_tdata,  // glyph_width[11:0], glyph_height[23:12]
    input  logic                  i_s_tuser,  // gray_bitmap
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // pos_x, pos_y, slot_width, slot_height, channel_index, page_number,
    // page_closed, oversize; zero padded to whole bytes
    output logic [((2*COORD_BITS+46+7)/8)*8-1:0] o_m_tdata,
    output logic                  o_m_tuser,  // placed
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CUR_W  = COORD_BITS + 1;
    localparam int DATA_W = 2*COORD_BITS + 2*SLOT_W + CHAN_W + PAGE_W + 2;
    localparam int OUT_W  = ((2*COORD_BITS + 46 + 7) / 8) * 8;

    t_cfg cfg;

    // input register
    logic               r_in_vld;
    logic [GLYPH_W-1:0] r_gw, r_gh;
    logic               r_gray;

    // packer state
    logic [CUR_W-1:0]  r_cx, r_cy;
    logic [SLOT_W-1:0] r_rh;
    logic [CHAN_W-1:0] r_ch;
    logic [PAGE_W-1:0] r_page;

    // result register
    logic              r_out_vld;
    logic              r_placed;
    logic [DATA_W-1:0] r_out_data;

    logic [CUR_W-1:0]      n_cx, n_cy;
    logic [SLOT_W-1:0]     n_rh;
    logic [CHAN_W-1:0]     n_ch;
    logic [PAGE_W-1:0]     n_page;
    logic [COORD_BITS-1:0] pos_x, pos_y;
    logic [SLOT_W-1:0]     slot_w, slot_h;
    logic                  closed, over;
    logic                  adv, fire;

    spr_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    spr_calc #(
        .COORD_BITS(COORD_BITS)
    ) u_calc (
        .i_cfg         (cfg),
        .i_glyph_width (r_gw),
        .i_glyph_height(r_gh),
        .i_cursor_x    (r_cx),
        .i_cursor_y    (r_cy),
        .i_row_height  (r_rh),
        .i_channel     (r_ch),
        .i_page        (r_page),
        .o_cursor_x    (n_cx),
        .o_cursor_y    (n_cy),
        .o_row_height  (n_rh),
        .o_channel     (n_ch),
        .o_page        (n_page),
        .o_pos_x       (pos_x),
        .o_pos_y       (pos_y),
        .o_slot_width  (slot_w),
        .o_slot_height (slot_h),
        .o_page_closed (closed),
        .o_oversize    (over)
    );

    assign adv        = !r_out_vld || i_m_tready;
    assign fire       = r_in_vld && adv;
    assign o_s_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_gw   <= i_s_tdata[11:0];
            r_gh   <= i_s_tdata[23:12];
            r_gray <= i_s_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= CUR_W'(PAGE_MARGIN_RST);
            r_cy   <= CUR_W'(PAGE_MARGIN_RST);
            r_rh   <= '0;
            r_ch   <= '0;
            r_page <= FIRST_PAGE;
        end else if (fire && r_gray) begin
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_rh   <= n_rh;
            r_ch   <= n_ch;
            r_page <= n_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_placed <= r_gray;
            if (r_gray) begin
                r_out_data <= {over, closed, n_page, n_ch, slot_h, slot_w, pos_y, pos_x};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tuser  = r_placed;
    assign o_m_tdata  = OUT_W'(r_out_data);

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the shelf rectangle packer: glyph beats, placement checks.
`timescale 1ns / 1ps

module testbench;
    import spr_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int PAGE_BURST    = 100;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam int unsigned CURSOR_MAX = 32767;

    typedef struct {
        bit        placed;
        bit [13:0] pos_x;
        bit [13:0] pos_y;
        bit [12:0] slot_w;
        bit [12:0] slot_h;
        bit [1:0]  chan;
        bit [15:0] page;
        bit        closed;
        bit        over;
    } t_placement;

    class placement_scoreboard;
        t_cfg         cfg;
        logic [14:0]  cursor_x;
        logic [14:0]  cursor_y;
        logic [12:0]  row_h;
        logic [1:0]   channel;
        logic [15:0]  page;
        t_placement   expected_slots[$];
        int           errors;

        function new();
            cfg.page_width   = PAGE_WIDTH_RST;
            cfg.page_height  = PAGE_HEIGHT_RST;
            cfg.page_margin  = PAGE_MARGIN_RST;
            cfg.glyph_margin = GLYPH_MARGIN_RST;
            cfg.multichannel = 1'b0;
            cursor_x = 15'(PAGE_MARGIN_RST);
            cursor_y = 15'(PAGE_MARGIN_RST);
            row_h    = '0;
            channel  = '0;
            page     = FIRST_PAGE;
            errors   = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            case (addr)
                REG_PAGE_WIDTH:   cfg.page_width   = data[13:0];
                REG_PAGE_HEIGHT:  cfg.page_height  = data[13:0];
                REG_PAGE_MARGIN:  cfg.page_margin  = data[7:0];
                REG_GLYPH_MARGIN: cfg.glyph_margin = data[7:0];
                REG_MULTICHANNEL: cfg.multichannel = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned sat_cursor(int unsigned v);
            return (v > CURSOR_MAX) ? CURSOR_MAX : v;
        endfunction

        function void bump_page();
            if (page < PAGE_MAX)
                page = page + 1'b1;
        endfunction

        function void note_glyph(logic [11:0] gw, logic [11:0] gh, logic gray);
            t_placement  slot;
            int unsigned sw, sh, pm, pw, ph;
            slot = '{default: 0};
            if (gray) begin
                pm = cfg.page_margin;
                pw = cfg.page_width;
                ph = cfg.page_height;
                sw = gw + 2 * cfg.glyph_margin;
                sh = gh + 2 * cfg.glyph_margin;
                slot.over = (sw + 2 * pm > pw) || (sh + 2 * pm > ph);
                // row full: open a new shelf under the tallest slot
                if (cursor_x + sw + pm > pw) begin
                    cursor_x = 15'(pm);
                    cursor_y = 15'(sat_cursor(cursor_y + row_h + pm));
                    row_h    = '0;
                end
                // page full: next channel, or a new page
                if (cursor_y + sh + pm > ph) begin
                    if (!cfg.multichannel) begin
                        bump_page();
                        slot.closed = 1'b1;
                    end else if (channel >= LAST_CHANNEL) begin
                        bump_page();
                        slot.closed = 1'b1;
                        channel = '0;
                    end else begin
                        channel = channel + 1'b1;
                    end
                    cursor_x = 15'(pm);
                    cursor_y = 15'(pm);
                    row_h    = '0;
                end
                slot.placed = 1'b1;
                slot.pos_x  = cursor_x[13:0];
                slot.pos_y  = cursor_y[13:0];
                slot.slot_w = 13'(sw);
                slot.slot_h = 13'(sh);
                slot.chan   = channel;
                slot.page   = page;
                cursor_x = 15'(sat_cursor(cursor_x + sw + pm));
                if (sh > row_h)
                    row_h = 13'(sh);
            end
            expected_slots = {expected_slots, slot};
        endfunction

        task report(string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_placement(logic [79:0] data, logic placed);
            t_placement e;
            if (expected_slots.size() == 0) begin
                report("result beat with nothing expected");
                return;
            end
            e = expected_slots.pop_front();
            if (placed !== e.placed)
                report($sformatf("placed %b exp %b", placed, e.placed));
            if (data[13:0] !== e.pos_x)
                report($sformatf("pos_x %0d exp %0d", data[13:0], e.pos_x));
            if (data[27:14] !== e.pos_y)
                report($sformatf("pos_y %0d exp %0d", data[27:14], e.pos_y));
            if (data[40:28] !== e.slot_w)
                report($sformatf("slot_width %0d exp %0d", data[40:28], e.slot_w));
            if (data[53:41] !== e.slot_h)
                report($sformatf("slot_height %0d exp %0d", data[53:41], e.slot_h));
            if (data[55:54] !== e.chan)
                report($sformatf("channel %0d exp %0d", data[55:54], e.chan));
            if (data[71:56] !== e.page)
                report($sformatf("page %0d exp %0d", data[71:56], e.page));
            if (data[72] !== e.closed)
                report($sformatf("page_closed %b exp %b", data[72], e.closed));
            if (data[73] !== e.over)
                report($sformatf("oversize %b exp %b", data[73], e.over));
            if (data[79:74] !== 6'd0)
                report($sformatf("pad bits %h not zero", data[79:74]));
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;   // glyph_width, glyph_height
    logic                  s_tuser = 1'b0; // gray_bitmap
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [79:0]           m_tdata;        // pos_x .. oversize, zero padded
    logic                  m_tuser;        // placed
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit                    no_idle = 1'b0;
    placement_scoreboard   sb = new();

    shelf_rectangle_packer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task send_glyph(input logic [11:0] gw, input logic [11:0] gh, input logic gray);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {gh, gw};
        s_tuser  <= gray;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_glyph(gw, gh, gray);
    endtask

    task send_random(input int n, input int max_dim);
        logic [11:0] gw, gh;
        repeat (n) begin
            gw = ($urandom_range(0, 15) == 0) ? 12'($urandom_range(0, 4095))
                                              : 12'($urandom_range(0, max_dim));
            gh = ($urandom_range(0, 15) == 0) ? 12'($urandom_range(0, 4095))
                                              : 12'($urandom_range(0, max_dim));
            send_glyph(gw, gh, $urandom_range(0, 9) != 0);
        end
    endtask

    // drop valid, then wait out every outstanding placement
    task drain();
        s_tvalid <= 1'b0;
        while (sb.expected_slots.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task program_page(input logic [13:0] pw, input logic [13:0] ph, input logic [13:0] pm,
                      input logic [13:0] gm, input logic [13:0] mc, input bit poke_unused);
        logic [CFG_ADDR_W-1:0] addr[6];
        logic [CFG_DATA_W-1:0] val[6];
        int n;
        addr = '{REG_PAGE_WIDTH, REG_PAGE_HEIGHT, REG_PAGE_MARGIN, REG_GLYPH_MARGIN,
                 REG_MULTICHANNEL, REG_UNUSED};
        val  = '{pw, ph, pm, gm, mc, 14'h3FFF};
        n = poke_unused ? 6 : 5;
        for (int i = 0; i < n; i++) begin
            cfg_valid <= 1'b1;
            cfg_addr  <= addr[i];
            cfg_data  <= val[i];
            @(posedge i_clk);
            while (!cfg_ready) @(posedge i_clk);
            sb.write_reg(addr[i], val[i]);
        end
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // result side: random stall per beat, none while no_idle is set
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            sb.check_placement(m_tdata, m_tuser);
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults after reset: corners of the glyph fields and shelf behavior
        send_glyph(12'd0, 12'd0, 1'b1);
        send_glyph(12'd4095, 12'd4095, 1'b0);
        send_glyph(12'd4095, 12'd4095, 1'b1);
        send_glyph(12'd1022, 12'd1022, 1'b1);
        send_glyph(12'd1023, 12'd1, 1'b1);
        send_glyph(12'd1, 12'd1023, 1'b1);
        send_glyph(12'd500, 12'd10, 1'b1);
        send_glyph(12'd500, 12'd10, 1'b1);
        send_glyph(12'd500, 12'd20, 1'b1);
        send_glyph(12'hAAA, 12'h555, 1'b1);
        send_glyph(12'h555, 12'hAAA, 1'b0);
        send_glyph(12'd0, 12'd0, 1'b0);
        repeat (5) send_glyph(12'd100, 12'd300, 1'b1);
        send_random(100, 300);
        drain();

        // tiny page, multichannel: channels roll over and pages close often
        program_page(14'd64, 14'd48, 14'd2, 14'd1, 14'd1, 1'b0);
        send_random(200, 20);
        while (sb.channel == 2'd0) send_glyph(12'd60, 12'd46, 1'b1);
        drain();

        // multichannel off with the channel left nonzero, no idling at all
        no_idle = 1'b1;
        program_page(14'd100, 14'd80, 14'd3, 14'd0, 14'd0, 1'b0);
        send_random(100, 40);
        drain();
        no_idle = 1'b0;

        // largest page and margins; upper data bits set on narrow registers
        program_page(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF, 1'b0);
        send_random(100, 4095);
        drain();

        // border margin wider than the page: every slot misses
        program_page(14'd100, 14'd100, 14'd200, 14'd0, 14'd0, 1'b0);
        send_random(30, 50);
        drain();

        // one page per glyph, back to back
        no_idle = 1'b1;
        program_page(14'd1, 14'd1, 14'd0, 14'd0, 14'd0, 1'b1);
        repeat (PAGE_BURST)
            send_glyph(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)), 1'b1);
        drain();
        no_idle = 1'b0;
        program_page(14'd1, 14'd1, 14'd0, 14'd0, 14'd1, 1'b0);
        send_random(12, 4095);
        drain();

        // back to a normal page; sender holds off once until all results are in
        program_page(14'd1024, 14'd1024, 14'd1, 14'd0, 14'd0, 1'b0);
        send_random(120, 200);
        drain();
        send_random(130, 200);
        drain();

        if (sb.expected_slots.size() != 0)
            sb.report("placements still expected at end");
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/spr_pkg.sv
src/spr_cfg.sv
src/spr_calc.sv
src/shelf_rectangle_packer_top.sv
verif/testbench.sv
